FILE: rtl/packet_framer_crc16_macros.svh
// assertion macros shared by the packet framer modules
// no dependencies; included by files that carry concurrent checks
`ifndef PACKET_FRAMER_CRC16_MACROS_SVH
`define PACKET_FRAMER_CRC16_MACROS_SVH

// expression must hold on every clock edge out of reset
`define PFC_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pfc_pkg.sv
// shared types, constants and the byte-wide crc function of the packet framer
// no dependencies; imported by every framer module
package pfc_pkg;

   localparam logic [15:0] CrcInit     = 16'hFFFF;
   localparam logic [15:0] CrcPoly     = 16'h1021;
   localparam logic [7:0]  MarkerReset = 8'hAA;

   localparam logic OpStart = 1'b0;
   localparam logic OpData  = 1'b1;

   // bytes per job: marker, command, length, crc high, crc low
   localparam int JobBytes    = 5;
   localparam int JobIdxBits  = $clog2(JobBytes);

   localparam int QueueDepth   = 2;
   localparam int QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   // one request's worth of output bytes
   typedef struct packed {
      logic [JobBytes-1:0][7:0] bytes;
      logic [JobIdxBits-1:0]    last_idx;
      logic                     closes;
      logic                     err;
   } job_type;

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CrcPoly) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

FILE: rtl/pfc_front.sv
// front end: accepts requests, tracks frame state and crc, builds output jobs
// depends on pfc_pkg and the assertion macro header
`include "packet_framer_crc16_macros.svh"

module pfc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  logic             req_valid,
   input  logic             req_opcode,
   input  logic [7:0]       req_command_byte,
   input  logic [7:0]       req_payload_length,
   input  logic [7:0]       req_payload_byte,
   input  logic             queue_full,
   output logic             req_ready,
   output logic             job_push,
   output pfc_pkg::job_type job
);
   import pfc_pkg::*;

   logic [7:0]  marker_ff, marker_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  remaining_ff, remaining_in;
   logic        open_ff, open_in;

   logic        accept;
   logic [15:0] hdr_crc;
   logic [15:0] dat_crc;
   logic [7:0]  rem_dec;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign job_push  = accept;

   assign hdr_crc = crc_fold(crc_fold(CrcInit, req_command_byte), req_payload_length);
   assign dat_crc = crc_fold(crc_ff, req_payload_byte);
   assign rem_dec = remaining_ff - 8'd1;

   always_comb begin
      marker_in    = csr_wr_en ? csr_wr_data : marker_ff;
      crc_in       = crc_ff;
      remaining_in = remaining_ff;
      open_in      = open_ff;
      job          = '0;
      if (req_opcode == OpStart) begin
         job.bytes[0] = marker_ff;
         job.bytes[1] = req_command_byte;
         job.bytes[2] = req_payload_length;
         job.bytes[3] = hdr_crc[15:8];
         job.bytes[4] = hdr_crc[7:0];
         if (req_payload_length == 8'd0) begin
            job.last_idx = JobIdxBits'(4);
            job.closes   = 1'b1;
            crc_in       = CrcInit;
            remaining_in = 8'd0;
            open_in      = 1'b0;
         end else begin
            job.last_idx = JobIdxBits'(2);
            crc_in       = hdr_crc;
            remaining_in = req_payload_length;
            open_in      = 1'b1;
         end
      end else if (!open_ff) begin
         // data with no open frame: one flagged zero byte, state untouched
         job.err = 1'b1;
      end else begin
         job.bytes[0] = req_payload_byte;
         job.bytes[1] = dat_crc[15:8];
         job.bytes[2] = dat_crc[7:0];
         if (rem_dec == 8'd0) begin
            job.last_idx = JobIdxBits'(2);
            job.closes   = 1'b1;
            crc_in       = CrcInit;
            remaining_in = 8'd0;
            open_in      = 1'b0;
         end else begin
            crc_in       = dat_crc;
            remaining_in = rem_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff    <= MarkerReset;
         crc_ff       <= CrcInit;
         remaining_ff <= 8'd0;
         open_ff      <= 1'b0;
      end else begin
         marker_ff <= marker_in;
         if (accept) begin
            crc_ff       <= crc_in;
            remaining_ff <= remaining_in;
            open_ff      <= open_in;
         end
      end
   end

   `PFC_ASSERT_NEXT(a_start_opens, clock, reset, accept && req_opcode == OpStart && req_payload_length != 8'd0, open_ff && remaining_ff == $past(req_payload_length), "start with payload did not open a frame")
   `PFC_ASSERT_HOLDS(a_open_has_count, clock, reset, open_ff == (remaining_ff != 8'd0), "open frame and byte count disagree")

endmodule

FILE: rtl/pfc_queue.sv
// short job queue between the front and back ends
// depends on pfc_pkg and the assertion macro header
`include "packet_framer_crc16_macros.svh"

module pfc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  pfc_pkg::job_type push_job,
   input  logic             pop,
   output logic             full,
   output logic             out_valid,
   output pfc_pkg::job_type out_job
);
   import pfc_pkg::*;

   job_type                 entries_ff [QueueDepth];
   logic [QueuePtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntBits-1:0] count_ff, count_in;

   logic do_push;
   logic do_pop;

   assign full      = (count_ff == QueueCntBits'(QueueDepth));
   assign out_valid = (count_ff != '0);
   assign out_job   = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueuePtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   `PFC_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= QueueCntBits'(QueueDepth), "queue count beyond depth")

endmodule

FILE: rtl/pfc_back.sv
// back end: walks one job at a time and presents its bytes on the result channel
// depends on pfc_pkg and the assertion macro header
`include "packet_framer_crc16_macros.svh"

module pfc_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  pfc_pkg::job_type job,
   input  logic             rsp_ready,
   output logic             job_pop,
   output logic             rsp_valid,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_end_of_frame,
   output logic             rsp_sequence_error
);
   import pfc_pkg::*;

   job_type               cur_ff;
   logic                  valid_ff;
   logic [JobIdxBits-1:0] idx_ff;

   logic at_last;
   logic take;

   assign at_last = (idx_ff == cur_ff.last_idx);
   // free to load when empty or the last byte goes out this cycle
   assign take    = !valid_ff || (rsp_ready && at_last);
   assign job_pop = take && job_valid;

   assign rsp_valid          = valid_ff;
   assign rsp_tx_byte        = cur_ff.bytes[idx_ff];
   assign rsp_end_of_frame   = cur_ff.closes && at_last;
   assign rsp_sequence_error = cur_ff.err;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (job_pop) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (take) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (rsp_ready) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job;
      end
   end

   `PFC_ASSERT_HOLDS(a_idx_in_job, clock, reset, !valid_ff || idx_ff <= cur_ff.last_idx, "byte index past end of job")
   `PFC_ASSERT_HOLDS(a_err_not_eof, clock, reset, !(valid_ff && cur_ff.err && rsp_end_of_frame), "flagged result marked end of frame")

endmodule

FILE: rtl/packet_framer_crc16.sv
// Packet framer with CRC-16 (poly 0x1021, init 0xFFFF, MSB first) trailer.
// A request is taken whenever the two-entry job queue has room, so data
// requests stream at one per cycle. The result channel moves one byte per
// cycle while rsp_ready is high: a start request yields 3 bytes (5 when its
// length is zero), a data request 1 byte (3 when it ends the frame), and that
// byte count per request sets the sustained rate while the queue is full.
// The crc of a byte is folded in the same cycle the request is taken.
// top level; depends on pfc_pkg, pfc_front, pfc_queue and pfc_back

module packet_framer_crc16 (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_opcode,
   input  logic [7:0] req_command_byte,
   input  logic [7:0] req_payload_length,
   input  logic [7:0] req_payload_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_end_of_frame,
   output logic       rsp_sequence_error
);
   import pfc_pkg::*;

   job_type push_job;
   job_type head_job;
   logic    push;
   logic    pop;
   logic    full;
   logic    head_valid;

   pfc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_opcode         (req_opcode),
      .req_command_byte   (req_command_byte),
      .req_payload_length (req_payload_length),
      .req_payload_byte   (req_payload_byte),
      .queue_full         (full),
      .req_ready          (req_ready),
      .job_push           (push),
      .job                (push_job)
   );

   pfc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (full),
      .out_valid (head_valid),
      .out_job   (head_job)
   );

   pfc_back u_back (
      .clock              (clock),
      .reset              (reset),
      .job_valid          (head_valid),
      .job                (head_job),
      .rsp_ready          (rsp_ready),
      .job_pop            (pop),
      .rsp_valid          (rsp_valid),
      .rsp_tx_byte        (rsp_tx_byte),
      .rsp_end_of_frame   (rsp_end_of_frame),
      .rsp_sequence_error (rsp_sequence_error)
   );

endmodule
